### rtl/lei_pkg.sv
// Package for the line edit input buffer: sizes, key codes, request and
// result types, state and pointer-unit encodings, ring slot helper.
// No dependencies.
`timescale 1ns / 1ps

package lei_pkg;

   localparam int DEPTH  = 128;
   localparam int SPAN   = 2 * DEPTH;
   localparam int PTR_W  = $clog2(SPAN);
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [7:0] KEY_NUL     = 8'h00;
   localparam logic [7:0] KEY_CTRL_D  = 8'h04;
   localparam logic [7:0] KEY_CTRL_H  = 8'h08;
   localparam logic [7:0] KEY_NEWLINE = 8'h0A;
   localparam logic [7:0] KEY_CTRL_P  = 8'h10;
   localparam logic [7:0] KEY_CTRL_U  = 8'h15;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] RD_NONE  = 2'd0;
   localparam logic [1:0] RD_DATA  = 2'd1;
   localparam logic [1:0] RD_EOF   = 2'd2;
   localparam logic [1:0] RD_EMPTY = 2'd3;

   typedef struct packed {
      logic       opcode;
      logic [7:0] key_char;
      logic       first_of_read;
   } req_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic [7:0] erase_count;
      logic       line_ready;
      logic [1:0] read_status;
      logic [7:0] read_char;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [1:0] {
      PTR_INC,
      PTR_DEC,
      PTR_DIST
   } ptr_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_STORE_CHK,
      S_STORE_ADV,
      S_STORE_FULL,
      S_KILL_TEST,
      S_KILL_CHK,
      S_READ_CHK
   } state_type;

   function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      if (p >= PTR_W'(DEPTH)) begin
         s = p - PTR_W'(DEPTH);
      end else begin
         s = p;
      end
      return s[SLOT_W-1:0];
   endfunction

endpackage

### rtl/lei_ptr_unit.sv
// Shared pointer arithmetic unit: increment, decrement and distance of
// ring pointers that count modulo twice the ring depth. Uses lei_pkg.
`timescale 1ns / 1ps

module lei_ptr_unit (
   input  lei_pkg::ptr_op_type        op,
   input  logic [lei_pkg::PTR_W-1:0]  a,
   input  logic [lei_pkg::PTR_W-1:0]  b,
   output logic [lei_pkg::PTR_W-1:0]  result
);

   logic [lei_pkg::PTR_W:0] wrap_sum;

   assign wrap_sum = {1'b0, a} + (lei_pkg::PTR_W + 1)'(lei_pkg::SPAN) - {1'b0, b};

   always_comb begin
      unique case (op)
         lei_pkg::PTR_INC: begin
            result = (a == lei_pkg::PTR_W'(lei_pkg::SPAN - 1)) ? '0 :
                     a + lei_pkg::PTR_W'(1);
         end
         lei_pkg::PTR_DEC: begin
            result = (a == '0) ? lei_pkg::PTR_W'(lei_pkg::SPAN - 1) :
                     a - lei_pkg::PTR_W'(1);
         end
         lei_pkg::PTR_DIST: begin
            result = (a >= b) ? a - b : wrap_sum[lei_pkg::PTR_W-1:0];
         end
         default: begin
            result = a;
         end
      endcase
   end

endmodule

### rtl/lei_store.sv
// Line store: the ring of key bytes, one write and one registered read
// port. Uses lei_pkg for its size and port struct.
`timescale 1ns / 1ps

module lei_store (
   input  logic                 clock,
   input  lei_pkg::mem_req_type mem_req,
   output logic [7:0]           rd_data
);

   logic [7:0] mem_ff [lei_pkg::DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lei_ctrl.sv
// Sequencer of the line edit input buffer: pointers, request decode and
// result register. Uses lei_pkg and the shared lei_ptr_unit.
`timescale 1ns / 1ps

module lei_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lei_pkg::req_type     req,
   output logic                 busy,
   output logic                 rsp_strobe,
   output lei_pkg::rsp_type     rsp,
   output lei_pkg::mem_req_type mem_req,
   input  logic [7:0]           rd_data
);

   lei_pkg::state_type        state_ff, state_in;
   lei_pkg::req_type          req_ff, req_in;
   logic [lei_pkg::PTR_W-1:0] read_ff, read_in;
   logic [lei_pkg::PTR_W-1:0] commit_ff, commit_in;
   logic [lei_pkg::PTR_W-1:0] edit_ff, edit_in;
   logic [lei_pkg::PTR_W-1:0] scan_ff, scan_in;
   logic [7:0]                count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lei_pkg::rsp_type          rsp_ff, rsp_in;

   lei_pkg::ptr_op_type       unit_op;
   logic [lei_pkg::PTR_W-1:0] unit_a;
   logic [lei_pkg::PTR_W-1:0] unit_b;
   logic [lei_pkg::PTR_W-1:0] unit_res;

   lei_ptr_unit u_ptr_unit (
      .op     (unit_op),
      .a      (unit_a),
      .b      (unit_b),
      .result (unit_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lei_pkg::S_IDLE;
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      scan_ff  <= scan_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      read_in         = read_ff;
      commit_in       = commit_ff;
      edit_in         = edit_ff;
      scan_in         = scan_ff;
      count_in        = count_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      unit_op         = lei_pkg::PTR_INC;
      unit_a          = edit_ff;
      unit_b          = read_ff;
      mem_req         = '0;
      mem_req.rd_addr = lei_pkg::ptr_slot(read_ff);

      unique case (state_ff)
         lei_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req;
               count_in = '0;
               state_in = lei_pkg::S_DISPATCH;
            end
         end
         lei_pkg::S_DISPATCH: begin
            if (req_ff.opcode == lei_pkg::OP_READ) begin
               if (read_ff == commit_ff) begin
                  rsp_in             = '0;
                  rsp_in.read_status = lei_pkg::RD_EMPTY;
                  rsp_valid_in       = 1'b1;
                  state_in           = lei_pkg::S_IDLE;
               end else begin
                  state_in = lei_pkg::S_READ_CHK;
               end
            end else begin
               case (req_ff.key_char) inside
                  lei_pkg::KEY_NUL, lei_pkg::KEY_CTRL_P: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = lei_pkg::S_IDLE;
                  end
                  lei_pkg::KEY_CTRL_U: begin
                     state_in = lei_pkg::S_KILL_TEST;
                  end
                  lei_pkg::KEY_CTRL_H: begin
                     unit_op = lei_pkg::PTR_DEC;
                     rsp_in  = '0;
                     if (edit_ff != commit_ff) begin
                        edit_in            = unit_res;
                        rsp_in.erase_count = 8'd1;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = lei_pkg::S_IDLE;
                  end
                  default: begin
                     state_in = lei_pkg::S_STORE_CHK;
                  end
               endcase
            end
         end
         lei_pkg::S_STORE_CHK: begin
            unit_op = lei_pkg::PTR_DIST;
            if (unit_res < lei_pkg::PTR_W'(lei_pkg::DEPTH)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = lei_pkg::ptr_slot(edit_ff);
               mem_req.wr_data = req_ff.key_char;
               state_in        = lei_pkg::S_STORE_ADV;
            end else begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = lei_pkg::S_IDLE;
            end
         end
         lei_pkg::S_STORE_ADV: begin
            unit_op  = lei_pkg::PTR_INC;
            edit_in  = unit_res;
            state_in = lei_pkg::S_STORE_FULL;
         end
         lei_pkg::S_STORE_FULL: begin
            unit_op           = lei_pkg::PTR_DIST;
            rsp_in            = '0;
            rsp_in.echo_valid = 1'b1;
            rsp_in.echo_char  = req_ff.key_char;
            if (req_ff.key_char == lei_pkg::KEY_NEWLINE ||
                req_ff.key_char == lei_pkg::KEY_CTRL_D ||
                unit_res == lei_pkg::PTR_W'(lei_pkg::DEPTH)) begin
               commit_in         = edit_ff;
               rsp_in.line_ready = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = lei_pkg::S_IDLE;
         end
         lei_pkg::S_KILL_TEST: begin
            unit_op = lei_pkg::PTR_DEC;
            if (edit_ff == commit_ff) begin
               rsp_in             = '0;
               rsp_in.erase_count = count_ff;
               rsp_valid_in       = 1'b1;
               state_in           = lei_pkg::S_IDLE;
            end else begin
               scan_in         = unit_res;
               mem_req.rd_addr = lei_pkg::ptr_slot(unit_res);
               state_in        = lei_pkg::S_KILL_CHK;
            end
         end
         lei_pkg::S_KILL_CHK: begin
            if (rd_data == lei_pkg::KEY_NEWLINE) begin
               rsp_in             = '0;
               rsp_in.erase_count = count_ff;
               rsp_valid_in       = 1'b1;
               state_in           = lei_pkg::S_IDLE;
            end else begin
               edit_in = scan_ff;
               if (count_ff != 8'hFF) begin
                  count_in = count_ff + 8'd1;
               end
               state_in = lei_pkg::S_KILL_TEST;
            end
         end
         lei_pkg::S_READ_CHK: begin
            unit_op = lei_pkg::PTR_INC;
            unit_a  = read_ff;
            rsp_in  = '0;
            if (rd_data == lei_pkg::KEY_CTRL_D) begin
               rsp_in.read_status = lei_pkg::RD_EOF;
               if (req_ff.first_of_read) begin
                  read_in = unit_res;
               end
            end else begin
               read_in            = unit_res;
               rsp_in.read_status = lei_pkg::RD_DATA;
               rsp_in.read_char   = rd_data;
            end
            rsp_valid_in = 1'b1;
            state_in     = lei_pkg::S_IDLE;
         end
         default: begin
            state_in = lei_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != lei_pkg::S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp        = rsp_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != lei_pkg::S_IDLE))
      else $error("result strobe without a request in progress");

   a_commit_moves_on_store: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && commit_ff != $past(commit_ff))
         |-> $past(state_ff == lei_pkg::S_STORE_FULL))
      else $error("commit pointer moved outside a stored key");

   a_read_moves_on_read: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && read_ff != $past(read_ff))
         |-> $past(state_ff == lei_pkg::S_READ_CHK))
      else $error("read pointer moved outside a read request");

endmodule

### rtl/line_edit_input_buffer_top.sv
// Top level of the line edit input buffer: joins the sequencer and the
// line store. Uses lei_pkg, lei_ctrl and lei_store.
// Ctrl-P, a zero key, Ctrl-H and an empty read are answered from the dispatch
// state; a read, or a key dropped on a full ring, from its check state; a
// stored key passes the store check, advance and full states; Ctrl-U loops
// through kill test and kill check per erased byte until the commit point or
// a stored newline. busy is low in the strobe cycle, so a request may follow.
// Synchronous reset empties the ring pointers; the results cannot be stalled.
`timescale 1ns / 1ps

module line_edit_input_buffer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lei_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lei_pkg::rsp_type rsp_payload
);

   lei_pkg::mem_req_type mem_req;
   logic [7:0]           rd_data;

   lei_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_payload),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   lei_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
